// ----- rtl/core/tcc_pkg.sv -----
package tcc_pkg;

	// Depth of the stack of earlier x positions.
	localparam int HISTORY_DEPTH = 256;
	localparam int HIST_IDX_W    = $clog2(HISTORY_DEPTH);
	localparam int HIST_CNT_W    = HIST_IDX_W + 1;

	// Coordinate and field widths.
	localparam int COORD_W = 12;
	localparam int ALU_W   = COORD_W + 1;
	localparam int SUM_W   = COORD_W + 2;
	localparam int LINE_W  = 8;
	localparam int CHAR_W  = 21;
	localparam int GLYPH_W = 8;

	// Tab stops every eight space widths; a scroll moves six lines.
	localparam int TAB_STOPS    = 8;
	localparam int TAB_W        = $clog2(TAB_STOPS);
	localparam int SCROLL_LINES = 6;
	localparam int SCROLL_W     = LINE_W + 3;

	// One quotient bit per step over the whole offset.
	localparam int DIV_STEPS = COORD_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Control characters.
	localparam logic [CHAR_W-1:0] CH_NL  = CHAR_W'(10);
	localparam logic [CHAR_W-1:0] CH_CR  = CHAR_W'(13);
	localparam logic [CHAR_W-1:0] CH_TAB = CHAR_W'(9);
	localparam logic [CHAR_W-1:0] CH_BS  = CHAR_W'(8);

	typedef enum logic [1:0] {
		CMD_DRAW   = 2'd0,
		CMD_CLEAR  = 2'd1,
		CMD_SCROLL = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		CFG_WIN_LEFT    = 3'd0,
		CFG_WIN_TOP     = 3'd1,
		CFG_WIN_RIGHT   = 3'd2,
		CFG_WIN_BOTTOM  = 3'd3,
		CFG_LINE_HEIGHT = 3'd4,
		CFG_SPACE_WIDTH = 3'd5
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_NL_SUM,
		ST_NL_CMP,
		ST_NL_BAND,
		ST_NL_TOPO,
		ST_NL_YCMP,
		ST_NL_EMIT,
		ST_NL_ADV,
		ST_TAB_OFF,
		ST_TAB_DIV,
		ST_TAB_MUL,
		ST_TAB_ADV,
		ST_BS_RD,
		ST_BS_ADD,
		ST_BS_EMIT,
		ST_CH_SUM,
		ST_CH_CMP,
		ST_CH_PUSH,
		ST_CH_YB,
		ST_CH_EMIT
	} state_t;

	// Clamp a grown sum to the largest coordinate.
	function automatic logic [COORD_W-1:0] sat12(input logic [SUM_W-1:0] v);
		sat12 = (|v[SUM_W-1:COORD_W]) ? {COORD_W{1'b1}} : v[COORD_W-1:0];
	endfunction

endpackage

// ----- rtl/core/text_console_cursor_engine.sv -----
// Carriage return, and backspace on an empty stack, are handled entirely on acceptance; other
// items step through their states, and an output stall holds them further. The last result of a
// backspace or glyph is loaded into the output register as the block turns ready; a newline
// loads its scroll result before its final cursor step. One item is in work at a time; the tab
// division runs on the 12-step restoring divider that shares the single add/subtract unit.
// Reset (arst_n low) puts the cursor at 0,0, empties the stack and loads the register
// defaults; the stack memory itself is not cleared.
module text_console_cursor_engine
	import tcc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Input stream; tdata: char_code[20:0], glyph_width[28:21], zero fill [31:29].
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,
	// Output stream; tdata: cmd[1:0], x_start[13:2], x_end[25:14], y_top[37:26],
	// y_bottom[49:38], glyph_code[70:50], zero fill [71].
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,
	output logic        m_axis_tlast,
	// Register write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	// Registers and state.
	state_t                state_q, state_d;
	logic [COORD_W-1:0]    win_left_q, win_top_q, win_right_q, win_bottom_q;
	logic [LINE_W-1:0]     line_height_q, space_width_q;
	logic [COORD_W-1:0]    cur_x_q, cur_x_d, cur_y_q, cur_y_d;
	logic [HIST_CNT_W-1:0] hist_cnt_q, hist_cnt_d;
	logic                  item_nl_q, item_nl_d;
	logic [CHAR_W-1:0]     char_q, char_d;
	logic [GLYPH_W-1:0]    width_q, width_d;
	logic [SUM_W-1:0]      tmp_q, tmp_d, yb_q, yb_d;
	logic [COORD_W-1:0]    band_q, band_d;
	logic [LINE_W-1:0]     rem_q, rem_d;
	logic [COORD_W-1:0]    quo_q, quo_d;
	logic [DIV_CNT_W-1:0]  dcnt_q, dcnt_d;

	// Output register.
	logic                  out_valid_q;
	cmd_t                  out_cmd_q, out_cmd_d;
	logic [COORD_W-1:0]    out_xs_q, out_xs_d, out_xe_q, out_xe_d;
	logic [COORD_W-1:0]    out_yt_q, out_yt_d, out_yb_q, out_yb_d;
	logic [CHAR_W-1:0]     out_glyph_q, out_glyph_d;
	logic                  out_last_q, out_last_d;
	logic                  out_load, can_load;

	// Stack memory.
	logic [COORD_W-1:0]    hist_mem [HISTORY_DEPTH];
	logic [COORD_W-1:0]    rd_q;
	logic                  mem_we, mem_re;
	logic [HIST_IDX_W-1:0] mem_raddr;
	logic [HIST_CNT_W-1:0] cnt_dec;

	// Shared add/subtract unit.
	logic [ALU_W-1:0]      alu_a, alu_b;
	logic                  alu_sub;
	logic [SUM_W-1:0]      alu_sum;
	logic                  alu_ge;

	// Helpers.
	logic                  s_accept;
	logic [HIST_CNT_W-1:0] cnt_start;
	logic [LINE_W-1:0]     sw_eff;
	logic [SCROLL_W-1:0]   scroll_ofs;
	logic [TAB_W:0]        tab_steps;
	logic [LINE_W-1:0]     rem_shift_lo;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign can_load      = !out_valid_q || m_axis_tready;

	// One add or subtract per cycle; ge is set when a difference is not negative.
	assign alu_sum = SUM_W'(alu_a) + (alu_sub ? ~SUM_W'(alu_b) : SUM_W'(alu_b))
		+ SUM_W'(alu_sub);
	assign alu_ge  = !alu_sum[SUM_W-1];

	assign cnt_start    = (hist_cnt_q >= HIST_CNT_W'(HISTORY_DEPTH)) ? '0 : hist_cnt_q;
	assign cnt_dec      = hist_cnt_q - HIST_CNT_W'(1);
	assign mem_raddr    = cnt_dec[HIST_IDX_W-1:0];
	assign sw_eff       = (space_width_q == '0) ? LINE_W'(1) : space_width_q;
	assign scroll_ofs   = (SCROLL_W'(line_height_q) << 2) + (SCROLL_W'(line_height_q) << 1);
	assign tab_steps    = (TAB_W+1)'(TAB_STOPS) - {1'b0, quo_q[TAB_W-1:0]};
	assign rem_shift_lo = {rem_q[LINE_W-2:0], quo_q[COORD_W-1]};

	// Sequencer: next state, datapath updates and unit operands.
	always_comb begin
		state_d     = state_q;
		cur_x_d     = cur_x_q;
		cur_y_d     = cur_y_q;
		hist_cnt_d  = hist_cnt_q;
		item_nl_d   = item_nl_q;
		char_d      = char_q;
		width_d     = width_q;
		tmp_d       = tmp_q;
		yb_d        = yb_q;
		band_d      = band_q;
		rem_d       = rem_q;
		quo_d       = quo_q;
		dcnt_d      = dcnt_q;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		alu_a       = '0;
		alu_b       = '0;
		alu_sub     = 1'b0;
		out_load    = 1'b0;
		out_cmd_d   = out_cmd_q;
		out_xs_d    = out_xs_q;
		out_xe_d    = out_xe_q;
		out_yt_d    = out_yt_q;
		out_yb_d    = out_yb_q;
		out_glyph_d = out_glyph_q;
		out_last_d  = out_last_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					char_d     = s_axis_tdata[CHAR_W-1:0];
					width_d    = s_axis_tdata[CHAR_W+GLYPH_W-1:CHAR_W];
					hist_cnt_d = cnt_start;
					item_nl_d  = 1'b0;
					priority if (s_axis_tdata[CHAR_W-1:0] == CH_NL) begin
						item_nl_d = 1'b1;
						state_d   = ST_NL_SUM;
					end else if (s_axis_tdata[CHAR_W-1:0] == CH_CR) begin
						hist_cnt_d = '0;
						cur_x_d    = win_left_q;
					end else if (s_axis_tdata[CHAR_W-1:0] == CH_TAB) begin
						state_d = ST_TAB_OFF;
					end else if (s_axis_tdata[CHAR_W-1:0] == CH_BS) begin
						if (cnt_start != '0) begin
							state_d = ST_BS_RD;
						end
					end else begin
						state_d = ST_CH_SUM;
					end
				end
			end
			// Newline: test whether the next line reaches or passes the bottom.
			ST_NL_SUM: begin
				alu_a   = ALU_W'(cur_y_q);
				alu_b   = ALU_W'(line_height_q);
				tmp_d   = alu_sum;
				state_d = ST_NL_CMP;
			end
			ST_NL_CMP: begin
				alu_a   = tmp_q[ALU_W-1:0];
				alu_b   = ALU_W'(win_bottom_q);
				alu_sub = 1'b1;
				state_d = alu_ge ? ST_NL_BAND : ST_NL_ADV;
			end
			ST_NL_BAND: begin
				alu_a   = ALU_W'(win_bottom_q);
				alu_b   = ALU_W'(scroll_ofs);
				alu_sub = 1'b1;
				band_d  = alu_ge ? alu_sum[COORD_W-1:0] : '0;
				state_d = ST_NL_TOPO;
			end
			// Cursor row less the scrolled amount, zero when it would go negative.
			ST_NL_TOPO: begin
				alu_a   = ALU_W'(cur_y_q);
				alu_b   = ALU_W'(scroll_ofs);
				alu_sub = 1'b1;
				tmp_d   = alu_ge ? alu_sum : '0;
				state_d = ST_NL_YCMP;
			end
			// Move the cursor up by the scrolled amount, stopping at the window top.
			ST_NL_YCMP: begin
				alu_a   = tmp_q[ALU_W-1:0];
				alu_b   = ALU_W'(win_top_q);
				alu_sub = 1'b1;
				cur_y_d = alu_ge ? tmp_q[COORD_W-1:0] : win_top_q;
				state_d = ST_NL_EMIT;
			end
			ST_NL_EMIT: begin
				if (can_load) begin
					out_load    = 1'b1;
					out_cmd_d   = CMD_SCROLL;
					out_xs_d    = win_left_q;
					out_xe_d    = win_right_q;
					out_yt_d    = band_q;
					out_yb_d    = win_bottom_q;
					out_glyph_d = '0;
					out_last_d  = item_nl_q;
					state_d     = ST_NL_ADV;
				end
			end
			ST_NL_ADV: begin
				alu_a      = ALU_W'(cur_y_q);
				alu_b      = ALU_W'(line_height_q);
				cur_y_d    = sat12(alu_sum);
				hist_cnt_d = '0;
				cur_x_d    = win_left_q;
				state_d    = item_nl_q ? ST_IDLE : ST_CH_PUSH;
			end
			// Tab: offset from the window left, clamped at zero.
			ST_TAB_OFF: begin
				alu_a   = ALU_W'(cur_x_q);
				alu_b   = ALU_W'(win_left_q);
				alu_sub = 1'b1;
				quo_d   = alu_ge ? alu_sum[COORD_W-1:0] : '0;
				rem_d   = '0;
				dcnt_d  = '0;
				state_d = ST_TAB_DIV;
			end
			// Restoring division, one quotient bit per cycle.
			ST_TAB_DIV: begin
				alu_a   = ALU_W'({rem_q, quo_q[COORD_W-1]});
				alu_b   = ALU_W'(sw_eff);
				alu_sub = 1'b1;
				rem_d   = alu_ge ? alu_sum[LINE_W-1:0] : rem_shift_lo;
				quo_d   = {quo_q[COORD_W-2:0], alu_ge};
				dcnt_d  = dcnt_q + DIV_CNT_W'(1);
				if (dcnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_TAB_MUL;
				end
			end
			ST_TAB_MUL: begin
				tmp_d      = SUM_W'(tab_steps) * SUM_W'(sw_eff);
				mem_we     = 1'b1;
				hist_cnt_d = hist_cnt_q + HIST_CNT_W'(1);
				state_d    = ST_TAB_ADV;
			end
			ST_TAB_ADV: begin
				alu_a   = ALU_W'(cur_x_q);
				alu_b   = tmp_q[ALU_W-1:0];
				cur_x_d = sat12(alu_sum);
				state_d = ST_IDLE;
			end
			// Backspace: pop, then clear the rectangle left behind.
			ST_BS_RD: begin
				mem_re     = 1'b1;
				hist_cnt_d = cnt_dec;
				state_d    = ST_BS_ADD;
			end
			ST_BS_ADD: begin
				alu_a   = ALU_W'(cur_y_q);
				alu_b   = ALU_W'(line_height_q);
				tmp_d   = alu_sum;
				state_d = ST_BS_EMIT;
			end
			ST_BS_EMIT: begin
				if (can_load) begin
					out_load    = 1'b1;
					out_cmd_d   = CMD_CLEAR;
					out_xs_d    = rd_q;
					out_xe_d    = cur_x_q;
					out_yt_d    = cur_y_q;
					out_yb_d    = sat12(tmp_q);
					out_glyph_d = '0;
					out_last_d  = 1'b1;
					cur_x_d     = rd_q;
					state_d     = ST_IDLE;
				end
			end
			// Printable character: wrap test against the right limit.
			ST_CH_SUM: begin
				alu_a   = ALU_W'(cur_x_q);
				alu_b   = ALU_W'(width_q);
				tmp_d   = alu_sum;
				state_d = ST_CH_CMP;
			end
			ST_CH_CMP: begin
				alu_a   = tmp_q[ALU_W-1:0];
				alu_b   = ALU_W'(win_right_q);
				alu_sub = 1'b1;
				state_d = alu_ge ? ST_NL_SUM : ST_CH_PUSH;
			end
			ST_CH_PUSH: begin
				mem_we     = 1'b1;
				hist_cnt_d = hist_cnt_q + HIST_CNT_W'(1);
				alu_a      = ALU_W'(cur_x_q);
				alu_b      = ALU_W'(width_q);
				tmp_d      = alu_sum;
				state_d    = ST_CH_YB;
			end
			ST_CH_YB: begin
				alu_a   = ALU_W'(cur_y_q);
				alu_b   = ALU_W'(line_height_q);
				yb_d    = alu_sum;
				state_d = ST_CH_EMIT;
			end
			ST_CH_EMIT: begin
				if (can_load) begin
					out_load    = 1'b1;
					out_cmd_d   = CMD_DRAW;
					out_xs_d    = cur_x_q;
					out_xe_d    = sat12(tmp_q);
					out_yt_d    = cur_y_q;
					out_yb_d    = sat12(yb_q);
					out_glyph_d = char_q;
					out_last_d  = 1'b1;
					cur_x_d     = sat12(tmp_q);
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Cursor, stack count and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			hist_cnt_q  <= '0;
			item_nl_q   <= 1'b0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cur_x_q    <= cur_x_d;
			cur_y_q    <= cur_y_d;
			hist_cnt_q <= hist_cnt_d;
			item_nl_q  <= item_nl_d;
			dcnt_q     <= dcnt_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Configuration registers; writes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_left_q    <= '0;
			win_top_q     <= '0;
			win_right_q   <= COORD_W'(640);
			win_bottom_q  <= COORD_W'(480);
			line_height_q <= LINE_W'(16);
			space_width_q <= LINE_W'(8);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WIN_LEFT:    win_left_q    <= cfg_data;
				CFG_WIN_TOP:     win_top_q     <= cfg_data;
				CFG_WIN_RIGHT:   win_right_q   <= cfg_data;
				CFG_WIN_BOTTOM:  win_bottom_q  <= cfg_data;
				CFG_LINE_HEIGHT: line_height_q <= cfg_data[LINE_W-1:0];
				CFG_SPACE_WIDTH: space_width_q <= cfg_data[LINE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Working and output payload registers.
	always_ff @(posedge clk) begin
		char_q      <= char_d;
		width_q     <= width_d;
		tmp_q       <= tmp_d;
		yb_q        <= yb_d;
		band_q      <= band_d;
		rem_q       <= rem_d;
		quo_q       <= quo_d;
		out_cmd_q   <= out_cmd_d;
		out_xs_q    <= out_xs_d;
		out_xe_q    <= out_xe_d;
		out_yt_q    <= out_yt_d;
		out_yb_q    <= out_yb_d;
		out_glyph_q <= out_glyph_d;
		out_last_q  <= out_last_d;
	end

	// Stack of earlier x positions: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			hist_mem[hist_cnt_q[HIST_IDX_W-1:0]] <= cur_x_q;
		end
		if (mem_re) begin
			rd_q <= hist_mem[mem_raddr];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {1'b0, out_glyph_q, out_yb_q, out_yt_q, out_xe_q, out_xs_q,
		out_cmd_q};

	// The stack count never goes past the depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		hist_cnt_q <= HIST_CNT_W'(HISTORY_DEPTH))
		else $error("stack count beyond depth");

	// A result never overwrites one that has not been transferred.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || m_axis_tready))
		else $error("pending result overwritten");

	// The tab product is formed only after all quotient bits are in.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAB_MUL) |-> ($past(state_q) == ST_TAB_DIV
			&& $past(dcnt_q) == DIV_CNT_W'(DIV_STEPS - 1)))
		else $error("division cut short");

	// A scroll result carries no glyph.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_cmd_q == CMD_SCROLL) |-> (out_glyph_q == '0))
		else $error("scroll result with glyph code");

endmodule

// ----- tb/sv/text_console_cursor_engine_test.sv -----
`timescale 1ns / 100ps

module text_console_cursor_engine_test;
	import tcc_pkg::*;

	localparam int MAX_CODE     = 1114111;
	localparam int COORD_MAX    = (1 << COORD_W) - 1;
	localparam int SETTLE_TICKS = 40;

	// One character as it travels on the input stream, code in the low bits.
	typedef struct packed {
		logic [GLYPH_W-1:0] width;
		logic [CHAR_W-1:0]  code;
	} console_char_t;

	// One drawing command as it leaves the block.
	typedef struct {
		cmd_t               cmd;
		logic [COORD_W-1:0] x_start;
		logic [COORD_W-1:0] x_end;
		logic [COORD_W-1:0] y_top;
		logic [COORD_W-1:0] y_bottom;
		logic [CHAR_W-1:0]  glyph;
		logic               last;
	} draw_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [11:0] cfg_data = '0;

	text_console_cursor_engine DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Window registers and cursor state as the block should hold them.
	int win_l = 0, win_t = 0, win_r = 640, win_b = 480, line_h = 16, space_w = 8;
	int cur_x = 0, cur_y = 0, depth_used = 0;
	logic [COORD_W-1:0] x_stack [HISTORY_DEPTH];

	console_char_t chars_to_send [$];
	draw_cmd_t     draw_cmds_due [$];
	console_char_t drv_char;

	int  chars_outstanding = 0;
	int  cmds_this_char;
	int  cmd_tally [3] = '{0, 0, 0};
	int  chars_taken = 0;
	int  cmds_checked = 0;
	int  reg_writes = 0;
	int  window_sets = 0;
	int  mismatches = 0;
	bit  char_taken = 1'b0;
	int  in_wait = 0;
	int  out_wait = 0;
	int  run_left [2] = '{0, 0};
	bit  no_idle [2] = '{1'b0, 1'b0};

	initial begin
		forever #1 clk = ~clk;
	end

	// Gap before the next transfer on one side; stretches of back-to-back traffic are mixed in.
	function automatic int next_gap(int side);
		if (run_left[side] == 0) begin
			run_left[side] = $urandom_range(10, 60);
			no_idle[side] = ($urandom_range(0, 2) == 0);
		end
		run_left[side]--;
		return no_idle[side] ? 0 : $urandom_range(0, 10);
	endfunction

	function automatic int clamp_coord(int v);
		return (v > COORD_MAX) ? COORD_MAX : v;
	endfunction

	task automatic push_cmd(cmd_t c, int xs, int xe, int yt, int yb, logic [CHAR_W-1:0] g);
		draw_cmd_t d;
		d.cmd      = c;
		d.x_start  = COORD_W'(xs);
		d.x_end    = COORD_W'(xe);
		d.y_top    = COORD_W'(yt);
		d.y_bottom = COORD_W'(yb);
		d.glyph    = g;
		d.last     = 1'b0;
		draw_cmds_due.push_back(d);
		cmd_tally[c]++;
		cmds_this_char++;
	endtask

	// Next line: scroll six lines up first when the new line would reach the bottom.
	task automatic line_feed();
		int shift, band;
		if (cur_y + line_h >= win_b) begin
			shift = SCROLL_LINES * line_h;
			band = (win_b >= shift) ? win_b - shift : 0;
			push_cmd(CMD_SCROLL, win_l, win_r, band, win_b, '0);
			if (cur_y >= win_t + shift) begin
				cur_y -= shift;
			end else begin
				cur_y = win_t;
			end
		end
		cur_y = clamp_coord(cur_y + line_h);
		depth_used = 0;
		cur_x = win_l;
	endtask

	// Moves the cursor for one character and queues the drawing commands it causes.
	task automatic advance_cursor(console_char_t c);
		int sw, off, steps, x0;
		draw_cmd_t tail;
		cmds_this_char = 0;
		if (depth_used >= HISTORY_DEPTH) begin
			depth_used = 0;
		end
		case (c.code)
			CH_NL: begin
				line_feed();
			end
			CH_CR: begin
				depth_used = 0;
				cur_x = win_l;
			end
			CH_TAB: begin
				sw = (space_w != 0) ? space_w : 1;
				off = (cur_x > win_l) ? cur_x - win_l : 0;
				steps = TAB_STOPS - ((off / sw) % TAB_STOPS);
				x_stack[depth_used] = COORD_W'(cur_x);
				depth_used++;
				cur_x = clamp_coord(cur_x + steps * sw);
			end
			CH_BS: begin
				if (depth_used > 0) begin
					depth_used--;
					x0 = x_stack[depth_used];
					push_cmd(CMD_CLEAR, x0, cur_x, cur_y, clamp_coord(cur_y + line_h), '0);
					cur_x = x0;
				end
			end
			default: begin
				if (cur_x + c.width >= win_r) begin
					line_feed();
				end
				if (depth_used >= HISTORY_DEPTH) begin
					depth_used = 0;
				end
				x_stack[depth_used] = COORD_W'(cur_x);
				depth_used++;
				push_cmd(CMD_DRAW, cur_x, clamp_coord(cur_x + c.width), cur_y,
					clamp_coord(cur_y + line_h), c.code);
				cur_x = clamp_coord(cur_x + c.width);
			end
		endcase
		if (cmds_this_char > 0) begin
			tail = draw_cmds_due.pop_back();
			tail.last = 1'b1;
			draw_cmds_due.push_back(tail);
		end
	endtask

	function automatic void compare_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Input driver: presents queued characters, with a random gap after each one.
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || char_taken)) begin
			char_taken = 1'b0;
			if (in_wait > 0) begin
				in_wait--;
				s_axis_tvalid <= 1'b0;
			end else if (chars_to_send.size() > 0) begin
				drv_char = chars_to_send.pop_front();
				s_axis_tdata <= {3'b000, drv_char};
				s_axis_tvalid <= 1'b1;
				in_wait = next_gap(0);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Output ready: held low for a random stall after each transfer.
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_wait > 0) begin
				out_wait--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Monitor: predicts on every accepted character and checks every drawing command.
	always @(posedge clk) begin : monitor
		draw_cmd_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				advance_cursor(drv_char);
				chars_outstanding--;
				chars_taken++;
				char_taken = 1'b1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				cmds_checked++;
				if (draw_cmds_due.size() == 0) begin
					$display("%0t: unexpected command, expected none, actual tdata %h last %b",
						$time, m_axis_tdata, m_axis_tlast);
					mismatches++;
				end else begin
					want = draw_cmds_due.pop_front();
					compare_field("cmd", want.cmd, m_axis_tdata[1:0]);
					compare_field("x_start", want.x_start, m_axis_tdata[13:2]);
					compare_field("x_end", want.x_end, m_axis_tdata[25:14]);
					compare_field("y_top", want.y_top, m_axis_tdata[37:26]);
					compare_field("y_bottom", want.y_bottom, m_axis_tdata[49:38]);
					compare_field("glyph_code", want.glyph, m_axis_tdata[70:50]);
					compare_field("zero fill", 0, m_axis_tdata[71]);
					compare_field("last", want.last, m_axis_tlast);
				end
				out_wait = next_gap(1);
			end
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [11:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_WIN_LEFT:    win_l = val;
			CFG_WIN_TOP:     win_t = val;
			CFG_WIN_RIGHT:   win_r = val;
			CFG_WIN_BOTTOM:  win_b = val;
			CFG_LINE_HEIGHT: line_h = val[7:0];
			CFG_SPACE_WIDTH: space_w = val[7:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_window(int l, int t, int r, int b, int lh, int sw);
		write_reg(CFG_WIN_LEFT, 12'(l));
		write_reg(CFG_WIN_TOP, 12'(t));
		write_reg(CFG_WIN_RIGHT, 12'(r));
		write_reg(CFG_WIN_BOTTOM, 12'(b));
		write_reg(CFG_LINE_HEIGHT, 12'(lh));
		write_reg(CFG_SPACE_WIDTH, 12'(sw));
		window_sets++;
	endtask

	// Waits until every character went in and every command came out, then lets the block settle.
	task automatic wait_drained();
		do @(negedge clk); while (chars_outstanding != 0 || draw_cmds_due.size() != 0);
		repeat (SETTLE_TICKS) @(negedge clk);
	endtask

	task automatic queue_char(int code, int width);
		console_char_t c;
		c.code = CHAR_W'(code);
		c.width = GLYPH_W'(width);
		chars_outstanding++;
		chars_to_send.push_back(c);
	endtask

	// Mostly printable glyphs, with a steady share of control characters.
	task automatic queue_random(int count, int wmax);
		int pick, code, width;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				code = CH_NL;
			end else if (pick < 16) begin
				code = CH_CR;
			end else if (pick < 30) begin
				code = CH_TAB;
			end else if (pick < 45) begin
				code = CH_BS;
			end else if (pick < 52) begin
				code = $urandom_range(0, MAX_CODE);
			end else begin
				code = $urandom_range(32, MAX_CODE);
			end
			width = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, wmax);
			queue_char(code, width);
		end
	endtask

	initial begin : stimulus
		int l, t, lh, sw;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Register defaults: code and width extremes, every control character, a wrap.
		queue_char(65, 8);
		queue_char(0, 0);
		queue_char(MAX_CODE, 255);
		queue_char(CH_TAB, 255);
		repeat (5) queue_char(CH_BS, 0);
		queue_char(CH_CR, 0);
		repeat (4) queue_char(66, 200);
		queue_char(CH_TAB, 0);
		repeat (10) queue_char(CH_NL, 17);
		wait_drained();

		// Empty window: every glyph wraps and every scroll band clamps at row zero.
		set_window(0, 0, 0, 0, 1, 1);
		queue_random(60, 10);
		wait_drained();

		// Everything at the top: coordinates saturate and scrolls stop at the window top.
		set_window(4095, 4095, 4095, 4095, 255, 255);
		queue_random(60, 255);
		wait_drained();

		// Cursor left of the window at a tab, and a zero space width.
		set_window(2000, 50, 3500, 900, 20, 0);
		queue_char(CH_TAB, 0);
		queue_char(CH_TAB, 99);
		queue_random(80, 60);
		wait_drained();

		// Overrun the x stack with tabs and narrow glyphs, then unwind part of it.
		set_window(0, 0, 4095, 4095, 1, 1);
		queue_char(CH_CR, 0);
		for (int i = 0; i < 262; i++) begin
			if ($urandom_range(0, 1) == 0) begin
				queue_char(CH_TAB, $urandom_range(0, 255));
			end else begin
				queue_char($urandom_range(32, MAX_CODE), $urandom_range(0, 1));
			end
		end
		repeat (12) queue_char(CH_BS, 0);
		wait_drained();

		// Random windows; the 8-bit registers sometimes get junk in the upper bits.
		for (int p = 0; p < 7; p++) begin
			l = $urandom_range(0, 1000);
			t = $urandom_range(0, 500);
			lh = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : $urandom_range(4, 40);
			sw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : $urandom_range(2, 20);
			if ($urandom_range(0, 3) == 0) begin
				lh += 256 * $urandom_range(1, 15);
				sw += 256 * $urandom_range(1, 15);
			end
			set_window(l, t, clamp_coord(l + $urandom_range(0, 2500)),
				clamp_coord(t + $urandom_range(0, 1500)), lh, sw);
			queue_random(120, $urandom_range(4, 80));
			wait_drained();
		end

		$display("Sent %0d characters over %0d window settings (%0d register writes).",
			chars_taken, window_sets + 1, reg_writes);
		$display("Checked %0d commands: %0d draws, %0d clears, %0d scrolls.",
			cmds_checked, cmd_tally[CMD_DRAW], cmd_tally[CMD_CLEAR], cmd_tally[CMD_SCROLL]);
		if (mismatches == 0) begin
			$display("text_console_cursor_engine_test passed");
		end else begin
			$display("text_console_cursor_engine_test failed");
		end
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("%0t: timeout with %0d characters and %0d commands outstanding",
			$time, chars_outstanding, draw_cmds_due.size());
		$display("text_console_cursor_engine_test failed");
		$finish;
	end

endmodule
